// ----- hw/rtl/hex_subchannel_point_locator_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the hex subchannel point locator
// Concurrent checks that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef HEX_SUBCHANNEL_POINT_LOCATOR_TOP_DEFINES_SVH
`define HEX_SUBCHANNEL_POINT_LOCATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold on every clock edge outside reset
`define HSPL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true outside reset
`define HSPL_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define HSPL_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSPL_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/hspl_pkg.sv -----
// ----------------------------------------------------------------------------
// hspl_pkg
// Shared widths, codes and control structs of the hex subchannel locator.
// ----------------------------------------------------------------------------
package hspl_pkg;

  localparam int MaxChannels = 512;
  localparam int CoordW      = 32;
  localparam int IdxW        = $clog2(MaxChannels);
  localparam int CntW        = 10;
  localparam int RegW        = 31;
  localparam int RingW       = 5;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_EDGE   = 2'd1;
  localparam logic [1:0] KIND_CORNER = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_FLAT_TO_FLAT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DUCT_GAP      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PIN_DIAMETER  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LATTICE_PITCH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RING_COUNT    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CHANNEL_COUNT = 3'd5;

  typedef enum logic [1:0] {
    SQ_AXES,
    SQ_LIMS,
    SQ_TOP,
    SQ_SCAN
  } sq_sel_e;

  typedef struct packed {
    logic            load_wr;
    logic            query_cap;
    logic            prep;
    sq_sel_e         sq_sel;
    logic            classify;
    logic            scan_rd;
    logic [IdxW-1:0] scan_addr;
    logic            res_load;
  } hspl_cmd_t;

  typedef struct packed {
    logic [CntW-1:0] scan_len;
    logic            pipe_busy;
  } hspl_sts_t;

endpackage

// ----- hw/rtl/hspl_if.sv -----
// ----------------------------------------------------------------------------
// hspl channel interfaces
// Valid/ready channels for query/load words, results and register writes.
// ----------------------------------------------------------------------------
interface hspl_in_if import hspl_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [IdxW-1:0]          entry_index;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic [1:0]               entry_type;

  modport source (output valid, command, entry_index, coord_x, coord_y, entry_type,
                  input ready);
  modport sink   (input valid, command, entry_index, coord_x, coord_y, entry_type,
                  output ready);
endinterface

interface hspl_out_if import hspl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] channel_index;

  modport source (output valid, channel_index, input ready);
  modport sink   (input valid, channel_index, output ready);
endinterface

interface hspl_cfg_if import hspl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/hspl_datapath.sv -----
// ----------------------------------------------------------------------------
// hspl_datapath
// Registers, channel table, sector classifier and nearest-entry scan pipe.
// ----------------------------------------------------------------------------
module hspl_datapath import hspl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic [IdxW-1:0]          in_entry_index_i,
  input  logic signed [CoordW-1:0] in_coord_x_i,
  input  logic signed [CoordW-1:0] in_coord_y_i,
  input  logic [1:0]               in_entry_type_i,
  input  hspl_cmd_t                cmd_i,
  output hspl_sts_t                sts_o,
  output logic [IdxW-1:0]          channel_index_o
);

  // configuration
  logic [RegW-1:0]  ftf_q, gap_q, pin_q, pitch_q;
  logic [RingW-1:0] ring_q;
  logic [CntW-1:0]  chan_q;

  // channel table
  logic [CoordW-1:0] mem_x [MaxChannels];
  logic [CoordW-1:0] mem_y [MaxChannels];
  logic [1:0]        mem_k [MaxChannels];

  // query state
  logic signed [CoordW-1:0] px_q, py_q;
  logic [CoordW-1:0]        ax_q, ay_q;
  logic signed [33:0]       lim_d_q;
  logic signed [36:0]       lim_l_q;
  logic [CoordW-1:0]        t1_q, t2_q, t3_q;
  logic                     t1_neg_q, t1_big_q, t2_neg_q, t2_big_q, t3_neg_q, t3_big_q;
  logic                     cen_pre_q, ax2_gt_q;
  logic [63:0]              sq_ax_q, sq_ay_q, sq_t1_q, sq_t2_q, sq_t3_q;
  logic [1:0]               want_q;

  // scan pipe
  logic                     v0_q, v1_q, v2_q, found_q;
  logic [IdxW-1:0]          i0_q, i1_q, i2_q, best_idx_q, res_q;
  logic [CoordW-1:0]        rd_x_q, rd_y_q, ex_q, ey_q;
  logic [1:0]               rd_k_q;
  logic                     ok1_q;
  logic [63:0]              sqx_q, sqy_q;
  logic [64:0]              best_q;

  // combinational
  logic signed [33:0] lim_d_c;
  logic signed [5:0]  ring_m1;
  logic signed [37:0] lim_l_full;
  logic signed [34:0] t1_c;
  logic signed [37:0] t2_c, t3_c;
  logic [CoordW-1:0]  op_a, op_b;
  logic [63:0]        ma, mb;
  logic [65:0]        lhs_x, lhs_y;
  logic               c1, gt_xy, c2, c3, corner, center;
  logic signed [32:0] dx_c, dy_c, adx_c, ady_c;
  logic [64:0]        sum_c;

  assign lim_d_c = $signed({3'b000, ftf_q}) - $signed({2'b00, gap_q, 1'b0})
                 - $signed({3'b000, pin_q});
  assign ring_m1    = $signed({1'b0, ring_q}) - 6'sd1;
  assign lim_l_full = 38'(ring_m1) * 38'($signed({1'b0, pitch_q}));

  assign t1_c = 35'(lim_d_q) - $signed({3'b000, ay_q});
  assign t2_c = $signed({6'b0, ax_q}) - 38'(lim_l_q);
  assign t3_c = $signed({6'b0, ax_q}) + 38'(lim_l_q);

  always_comb begin
    case (cmd_i.sq_sel)
      SQ_AXES: begin op_a = ax_q; op_b = ay_q; end
      SQ_LIMS: begin op_a = t1_q; op_b = t2_q; end
      SQ_TOP:  begin op_a = t3_q; op_b = t3_q; end
      default: begin op_a = ex_q; op_b = ey_q; end
    endcase
  end
  assign ma = 64'(op_a) * 64'(op_a);
  assign mb = 64'(op_b) * 64'(op_b);

  // sign of sqrt(3)*c - t done on squares
  assign lhs_x  = {2'b00, sq_ax_q} + {1'b0, sq_ax_q, 1'b0};
  assign lhs_y  = {2'b00, sq_ay_q} + {1'b0, sq_ay_q, 1'b0};
  assign c1     = !t1_neg_q && (t1_big_q || (lhs_x < {2'b00, sq_t1_q}));
  assign gt_xy  = lhs_x > {2'b00, sq_ay_q};
  assign c2     = !t2_neg_q && (t2_big_q || (lhs_y < {2'b00, sq_t2_q}));
  assign c3     = t3_neg_q || (!t3_big_q && (lhs_y > {2'b00, sq_t3_q}));
  assign center = cen_pre_q && c1;
  assign corner = lim_l_q[36] ? 1'b1 : (gt_xy ? (c2 || c3) : ax2_gt_q);

  assign dx_c  = $signed({px_q[CoordW-1], px_q}) - $signed({rd_x_q[CoordW-1], rd_x_q});
  assign dy_c  = $signed({py_q[CoordW-1], py_q}) - $signed({rd_y_q[CoordW-1], rd_y_q});
  assign adx_c = dx_c[32] ? -dx_c : dx_c;
  assign ady_c = dy_c[32] ? -dy_c : dy_c;
  assign sum_c = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ftf_q   <= '0;
      gap_q   <= '0;
      pin_q   <= '0;
      pitch_q <= '0;
      ring_q  <= RingW'(1);
      chan_q  <= CntW'(1);
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FLAT_TO_FLAT:  ftf_q   <= cfg_data_i[RegW-1:0];
          REG_DUCT_GAP:      gap_q   <= cfg_data_i[RegW-1:0];
          REG_PIN_DIAMETER:  pin_q   <= cfg_data_i[RegW-1:0];
          REG_LATTICE_PITCH: pitch_q <= cfg_data_i[RegW-1:0];
          REG_RING_COUNT:    ring_q  <= cfg_data_i[RingW-1:0];
          REG_CHANNEL_COUNT: chan_q  <= cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      v0_q <= cmd_i.scan_rd;
      v1_q <= v0_q;
      v2_q <= v1_q && ok1_q;
      if (cmd_i.classify) begin
        found_q <= 1'b0;
      end else if (v2_q) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      mem_x[in_entry_index_i] <= in_coord_x_i;
      mem_y[in_entry_index_i] <= in_coord_y_i;
      mem_k[in_entry_index_i] <= in_entry_type_i;
    end
    if (cmd_i.scan_rd) begin
      rd_x_q <= mem_x[cmd_i.scan_addr];
      rd_y_q <= mem_y[cmd_i.scan_addr];
      rd_k_q <= mem_k[cmd_i.scan_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_cap) begin
      px_q    <= in_coord_x_i;
      py_q    <= in_coord_y_i;
      ax_q    <= in_coord_x_i[CoordW-1] ? 32'(-in_coord_x_i) : in_coord_x_i;
      ay_q    <= in_coord_y_i[CoordW-1] ? 32'(-in_coord_y_i) : in_coord_y_i;
      lim_d_q <= lim_d_c;
      lim_l_q <= $signed(lim_l_full[36:0]);
    end
    if (cmd_i.prep) begin
      t1_q      <= t1_c[31:0];
      t1_neg_q  <= t1_c[34];
      t1_big_q  <= !t1_c[34] && (|t1_c[33:32]);
      t2_q      <= t2_c[31:0];
      t2_neg_q  <= t2_c[37];
      t2_big_q  <= !t2_c[37] && (|t2_c[36:32]);
      t3_q      <= t3_c[31:0];
      t3_neg_q  <= t3_c[37];
      t3_big_q  <= !t3_c[37] && (|t3_c[36:32]);
      cen_pre_q <= $signed({2'b00, ay_q, 1'b0}) < 35'(lim_d_q);
      ax2_gt_q  <= $signed({5'b0, ax_q, 1'b0}) > 38'(lim_l_q);
    end
    case (cmd_i.sq_sel)
      SQ_AXES: begin sq_ax_q <= ma; sq_ay_q <= mb; end
      SQ_LIMS: begin sq_t1_q <= ma; sq_t2_q <= mb; end
      SQ_TOP:  sq_t3_q <= ma;
      default: begin sqx_q <= ma; sqy_q <= mb; end
    endcase
    if (cmd_i.classify) begin
      want_q     <= center ? KIND_CENTER : (corner ? KIND_CORNER : KIND_EDGE);
      best_idx_q <= '0;
    end else if (v2_q && (!found_q || (sum_c < best_q))) begin
      best_q     <= sum_c;
      best_idx_q <= i2_q;
    end
    i0_q  <= cmd_i.scan_addr;
    i1_q  <= i0_q;
    i2_q  <= i1_q;
    ex_q  <= adx_c[31:0];
    ey_q  <= ady_c[31:0];
    ok1_q <= rd_k_q == want_q;
    if (cmd_i.res_load) begin
      res_q <= best_idx_q;
    end
  end

  assign sts_o.scan_len  = (chan_q >= CntW'(MaxChannels)) ? CntW'(MaxChannels) : chan_q;
  assign sts_o.pipe_busy = v0_q || v1_q || v2_q;
  assign channel_index_o = res_q;

endmodule

// ----- hw/rtl/hspl_ctrl.sv -----
// ----------------------------------------------------------------------------
// hspl_ctrl
// Sequencer: load/query dispatch, classify steps, table scan, result slot.
// ----------------------------------------------------------------------------
`include "hex_subchannel_point_locator_top_defines.svh"

module hspl_ctrl import hspl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_command_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  input  hspl_sts_t sts_i,
  output hspl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SQ_AXES,
    ST_SQ_LIMS,
    ST_SQ_TOP,
    ST_CLASSIFY,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] scan_cnt_q;
  logic            out_valid_q;
  logic            slot_free;

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.sq_sel    = SQ_SCAN;
    cmd_o.scan_addr = scan_cnt_q[IdxW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_wr   = in_valid_i && (in_command_i == CMD_LOAD);
        cmd_o.query_cap = in_valid_i && (in_command_i == CMD_LOCATE);
      end
      ST_PREP:     cmd_o.prep     = 1'b1;
      ST_SQ_AXES:  cmd_o.sq_sel   = SQ_AXES;
      ST_SQ_LIMS:  cmd_o.sq_sel   = SQ_LIMS;
      ST_SQ_TOP:   cmd_o.sq_sel   = SQ_TOP;
      ST_CLASSIFY: cmd_o.classify = 1'b1;
      ST_SCAN:     cmd_o.scan_rd  = 1'b1;
      ST_DRAIN:    ;
      ST_FINISH:   cmd_o.res_load = slot_free;
      default:     ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i && (in_command_i == CMD_LOCATE)) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP:    state_q <= ST_SQ_AXES;
        ST_SQ_AXES: state_q <= ST_SQ_LIMS;
        ST_SQ_LIMS: state_q <= ST_SQ_TOP;
        ST_SQ_TOP:  state_q <= ST_CLASSIFY;
        ST_CLASSIFY: begin
          scan_cnt_q <= '0;
          state_q    <= (sts_i.scan_len == '0) ? ST_FINISH : ST_SCAN;
        end
        ST_SCAN: begin
          scan_cnt_q <= scan_cnt_q + 1'b1;
          if (scan_cnt_q + 1'b1 == sts_i.scan_len) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!sts_i.pipe_busy) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `HSPL_ASSERT(a_res_slot_free, clk_i, rst_ni, cmd_o.res_load |-> (!out_valid_q || out_ready_i), "result overwrites a pending word")
  `HSPL_ASSERT(a_query_starts, clk_i, rst_ni, (state_q == ST_IDLE && in_valid_i && in_command_i == CMD_LOCATE) |=> (state_q == ST_PREP), "accepted query did not start")
  `HSPL_NEVER(a_scan_in_range, clk_i, rst_ni, (state_q == ST_SCAN) && (scan_cnt_q >= sts_i.scan_len), "scan address past channel count")
  `HSPL_NEVER(a_finish_drained, clk_i, rst_ni, (state_q == ST_FINISH) && sts_i.pipe_busy, "result taken before scan drained")

endmodule

// ----- hw/rtl/hex_subchannel_point_locator_top.sv -----
// ----------------------------------------------------------------------------
// hex_subchannel_point_locator_top
// Finds the nearest qualifying subchannel of a hexagonal assembly.
// ----------------------------------------------------------------------------
// Channels: in_i takes load and locate words, out_o returns one channel
// index per locate, cfg_i writes the geometry and scan-length registers
// (always ready; write only while the block is idle).
// A load word writes one table entry.
// A locate word is first classified in the prep, axis, limit, top and
// classify steps (one pair of shared 32x32 squarers); then the first
// n = min(channel_count, 512) table entries are scanned at one entry per cycle
// through the table's single read port, followed by a drain of the read pipe
// and the result handoff. When n is 0 the scan and the drain are skipped.
// One word is in flight at a time; in_i is ready again right after the
// result is parked in the output register, even if out_o is stalled.
// A stalled out_o holds its word; a following locate waits at its end
// until that slot is taken.
// Reset clears the registers to their defaults (ring and channel count 1);
// the table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module hex_subchannel_point_locator_top import hspl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hspl_in_if.sink     in_i,
  hspl_out_if.source  out_o,
  hspl_cfg_if.sink    cfg_i
);

  hspl_cmd_t cmd;
  hspl_sts_t sts;

  assign cfg_i.ready = 1'b1;

  hspl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  hspl_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .in_entry_index_i (in_i.entry_index),
    .in_coord_x_i     (in_i.coord_x),
    .in_coord_y_i     (in_i.coord_y),
    .in_entry_type_i  (in_i.entry_type),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .channel_index_o  (out_o.channel_index)
  );

endmodule

// ----- tb/sv/tb_hex_subchannel_point_locator_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for hex_subchannel_point_locator_top
// A directed table walks loads, locates and register writes at the extremes.
// A random part then fills the table and runs many geometry settings.
// Results are checked against a local predictor, while both channels idle
// in random bursts.
// ----------------------------------------------------------------------------
module tb_hex_subchannel_point_locator_top;
  import hspl_pkg::*;

  typedef enum int {ROW_LOAD, ROW_LOCATE, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e     op;
    logic [8:0]  idx;    // entry index, or register index for ROW_CFG
    logic [31:0] x;      // coord_x, or write data for ROW_CFG
    logic [31:0] y;
    logic [1:0]  kind;
    bit          typed;  // expected index given in the row
    logic [8:0]  exp;
  } dir_row_t;

  logic clk;
  logic rst_n;

  hspl_in_if  in_if ();
  hspl_out_if out_if ();
  hspl_cfg_if cfg_if ();

  hex_subchannel_point_locator_top uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // predictor state
  logic [31:0] tbl_x    [MaxChannels];
  logic [31:0] tbl_y    [MaxChannels];
  logic [1:0]  tbl_kind [MaxChannels];
  logic [30:0] geo_ftf, geo_gap, geo_pin, geo_pitch;
  logic [4:0]  geo_rings;
  logic [9:0]  scan_count;

  logic [8:0] nearest_q [$];
  int         mismatches;
  bit         quiet;
  int         out_stall;

  always #4 clk = ~clk;

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end

  // sign of sqrt(3)*c - t, c >= 0
  function automatic int sign_root3(longint c, longint t);
    longint unsigned lhs, rhs;
    if (t < 0) return 1;
    if (t > 64'sh0FFFFFFFF) return -1;
    lhs = 64'd3 * c * c;
    rhs = t * t;
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic logic [8:0] nearest_channel(logic [31:0] qx, logic [31:0] qy);
    longint px, py, ax, ay, lim_d, lim_l, dx, dy;
    longint unsigned sx, sy;
    logic [64:0] sq_dist, best_d;
    bit center, corner, found, ok;
    int n;
    logic [8:0] best;
    px = longint'($signed(qx));
    py = longint'($signed(qy));
    ax = px < 0 ? -px : px;
    ay = py < 0 ? -py : py;
    lim_d = longint'(geo_ftf) - 2 * longint'(geo_gap) - longint'(geo_pin);
    center = (2 * ay < lim_d) && (sign_root3(ax, lim_d - ay) < 0);
    lim_l = (longint'(geo_rings) - 1) * longint'(geo_pitch);
    if (lim_l < 0)
      corner = 1;
    else if (sign_root3(ax, ay) > 0)
      corner = (sign_root3(ay, ax - lim_l) < 0) || (sign_root3(ay, ax + lim_l) > 0);
    else
      corner = 2 * ax > lim_l;
    n = scan_count < MaxChannels ? int'(scan_count) : MaxChannels;
    found = 0;
    best = '0;
    best_d = '0;
    for (int i = 0; i < n; i++) begin
      if (center) ok = (tbl_kind[i] == KIND_CENTER);
      else ok = (tbl_kind[i] == (corner ? KIND_CORNER : KIND_EDGE));
      if (ok) begin
        dx = px - longint'($signed(tbl_x[i]));
        dy = py - longint'($signed(tbl_y[i]));
        sx = dx < 0 ? -dx : dx;
        sy = dy < 0 ? -dy : dy;
        sq_dist = {1'b0, sx * sx} + {1'b0, sy * sy};
        if (!found || sq_dist < best_d) begin
          found = 1;
          best_d = sq_dist;
          best = i[8:0];
        end
      end
    end
    return best;
  endfunction

  function automatic void set_geometry(logic [2:0] ridx, logic [31:0] data);
    case (ridx)
      REG_FLAT_TO_FLAT:  geo_ftf = data[30:0];
      REG_DUCT_GAP:      geo_gap = data[30:0];
      REG_PIN_DIAMETER:  geo_pin = data[30:0];
      REG_LATTICE_PITCH: geo_pitch = data[30:0];
      REG_RING_COUNT:    geo_rings = data[4:0];
      REG_CHANNEL_COUNT: scan_count = data[9:0];
      default: ;
    endcase
  endfunction

  // word on the input channel; valid stays high until a gap or a register write
  task automatic send_word(logic cmd, logic [8:0] idx, logic [31:0] x, logic [31:0] y,
                           logic [1:0] kind, bit typed, logic [8:0] exp);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.entry_index <= idx;
    in_if.coord_x     <= x;
    in_if.coord_y     <= y;
    in_if.entry_type  <= kind;
    do @(posedge clk); while (!in_if.ready);
    if (cmd == CMD_LOAD) begin
      tbl_x[idx]    = x;
      tbl_y[idx]    = y;
      tbl_kind[idx] = kind;
    end else begin
      nearest_q.push_back(typed ? exp : nearest_channel(x, y));
    end
  endtask

  // register write, only with the block idle
  task automatic write_reg(logic [2:0] ridx, logic [31:0] data);
    in_if.valid <= 1'b0;
    do @(posedge clk); while (nearest_q.size() != 0);
    repeat (20) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= ridx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    set_geometry(ridx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(longint span);
    longint v;
    if ($urandom_range(0, 4) == 0) return $urandom;
    v = longint'($urandom_range(0, 32'hFFFFFFFF)) % (4 * span + 1) - 2 * span;
    return v[31:0];
  endfunction

  function automatic logic [1:0] rand_kind();
    return $urandom_range(0, 7) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
  endfunction

  // result side: random stall bursts and the compare
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (nearest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: channel_index %0d",
                                         out_if.channel_index);
        end else begin
          if (out_if.channel_index !== nearest_q[0]) begin
            mismatches++;
            if (mismatches <= 10) $display("channel_index mismatch: expected %0d, got %0d",
                                           nearest_q[0], out_if.channel_index);
          end
          void'(nearest_q.pop_front());
        end
      end
      if (out_stall > 0) begin
        out_if.ready <= 1'b0;
        out_stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) out_stall = $urandom_range(1, 7);
      end
    end
  end

  dir_row_t rows [] = '{
    '{ROW_LOAD,   9'd0, 32'h00000000, 32'h00000000, KIND_EDGE,   1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h00000000, 32'h00000000, 2'd0,        1'b1, 9'd0},
    '{ROW_LOAD,   9'd1, 32'h7FFFFFFF, 32'h80000000, KIND_CORNER, 1'b0, 9'd0},
    '{ROW_LOAD,   9'd2, 32'h80000000, 32'h7FFFFFFF, KIND_CENTER, 1'b0, 9'd0},
    '{ROW_LOAD,   9'd3, 32'h00010000, 32'hFFFF0000, 2'd3,        1'b0, 9'd0},
    // one entry scanned: always entry 0
    '{ROW_LOCATE, 9'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 2'd0,        1'b1, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h80000000, 32'h80000000, 2'd0,        1'b1, 9'd0},
    '{ROW_CFG,    9'(REG_CHANNEL_COUNT), 32'd4, 32'd0, 2'd0,    1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h00000000, 32'h00000000, 2'd0,        1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h7FFFFFFF, 32'h80000000, 2'd0,        1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h00000000, 32'h00400000, 2'd0,        1'b0, 9'd0},
    '{ROW_CFG,    9'(REG_FLAT_TO_FLAT), 32'h7FFFFFFF, 32'd0, 2'd0, 1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h00000000, 32'h00000000, 2'd0,        1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h80000000, 32'h7FFFFFFF, 2'd0,        1'b0, 9'd0},
    '{ROW_CFG,    9'(REG_DUCT_GAP), 32'h7FFFFFFF, 32'd0, 2'd0,  1'b0, 9'd0},
    '{ROW_CFG,    9'(REG_PIN_DIAMETER), 32'h7FFFFFFF, 32'd0, 2'd0, 1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h00010000, 32'h00000000, 2'd0,        1'b0, 9'd0},
    '{ROW_CFG,    9'(REG_RING_COUNT), 32'd16, 32'd0, 2'd0,      1'b0, 9'd0},
    '{ROW_CFG,    9'(REG_LATTICE_PITCH), 32'h7FFFFFFF, 32'd0, 2'd0, 1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h7FFFFFFF, 32'h00000000, 2'd0,        1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h00000000, 32'h80000000, 2'd0,        1'b0, 9'd0},
    // ring count zero: every outer point goes to corners
    '{ROW_CFG,    9'(REG_RING_COUNT), 32'd0, 32'd0, 2'd0,       1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h00010000, 32'h00020000, 2'd0,        1'b0, 9'd0},
    // nothing scanned: result 0
    '{ROW_CFG,    9'(REG_CHANNEL_COUNT), 32'd0, 32'd0, 2'd0,    1'b0, 9'd0},
    '{ROW_LOCATE, 9'd0, 32'h12345678, 32'h9ABCDEF0, 2'd0,        1'b1, 9'd0}
  };

  initial begin
    longint span;
    int      sel;
    clk             = 1'b0;
    rst_n           = 1'b0;
    quiet           = 1'b0;
    mismatches      = 0;
    out_stall       = 0;
    in_if.valid       = 1'b0;
    in_if.command     = CMD_LOAD;
    in_if.entry_index = '0;
    in_if.coord_x     = '0;
    in_if.coord_y     = '0;
    in_if.entry_type  = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    geo_ftf = '0; geo_gap = '0; geo_pin = '0; geo_pitch = '0;
    geo_rings = 5'd1; scan_count = 10'd1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      case (rows[r].op)
        ROW_LOAD:   send_word(CMD_LOAD, rows[r].idx, rows[r].x, rows[r].y, rows[r].kind,
                              1'b0, 9'd0);
        ROW_LOCATE: send_word(CMD_LOCATE, rows[r].idx, rows[r].x, rows[r].y, rows[r].kind,
                              rows[r].typed, rows[r].exp);
        default:    write_reg(rows[r].idx[2:0], rows[r].x);
      endcase
    end

    // fill the whole table so that any scan length reads written entries
    span = 64'd1 << 24;
    for (int i = 0; i < MaxChannels; i++)
      send_word(CMD_LOAD, i[8:0], rand_coord(span), rand_coord(span), rand_kind(), 1'b0, 9'd0);

    for (int ph = 0; ph < 18; ph++) begin
      if (ph == 17) quiet = 1'b1;
      span = 64'd1 << $urandom_range(14, 30);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_FLAT_TO_FLAT, $urandom);
        write_reg(REG_DUCT_GAP, $urandom);
        write_reg(REG_PIN_DIAMETER, $urandom);
        write_reg(REG_LATTICE_PITCH, $urandom);
      end else begin
        write_reg(REG_FLAT_TO_FLAT, 32'($urandom_range(0, 32'(2 * span))));
        write_reg(REG_DUCT_GAP, 32'($urandom_range(0, 32'(span / 8))));
        write_reg(REG_PIN_DIAMETER, 32'($urandom_range(0, 32'(span / 8))));
        write_reg(REG_LATTICE_PITCH, 32'($urandom_range(0, 32'(span / 4))));
      end
      write_reg(REG_RING_COUNT, $urandom_range(0, 31));
      sel = $urandom_range(0, 9);
      case (sel)
        0:       write_reg(REG_CHANNEL_COUNT, 32'd512);
        1:       write_reg(REG_CHANNEL_COUNT, 32'd1023);
        2:       write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 1023));
        default: write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 48));
      endcase
      for (int k = 0; k < 35; k++) begin
        if ($urandom_range(0, 9) < 7)
          send_word(CMD_LOCATE, 9'($urandom_range(0, 511)), rand_coord(span),
                    rand_coord(span), 2'($urandom_range(0, 3)), 1'b0, 9'd0);
        else
          send_word(CMD_LOAD, 9'($urandom_range(0, 511)), rand_coord(span),
                    rand_coord(span), rand_kind(), 1'b0, 9'd0);
      end
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (nearest_q.size() != 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && nearest_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- hex_subchannel_point_locator_top.f -----
+incdir+hw/rtl
hw/rtl/hspl_pkg.sv
hw/rtl/hspl_if.sv
hw/rtl/hspl_datapath.sv
hw/rtl/hspl_ctrl.sv
hw/rtl/hex_subchannel_point_locator_top.sv
tb/sv/tb_hex_subchannel_point_locator_top.sv
